@@ rtl/set_assoc_cache_controller_top_assert.svh @@
// ----------------------------------------------------------------------------
// Cache controller assertion macros
// Property wrappers on the shared clock and reset of the cache controller.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_CONTROLLER_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define SACC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sacc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cache controller package
// Geometry constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacc_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int WAY_W      = 3;
   localparam int WCNT_W     = 4;
   localparam int MAX_SETS   = 64;
   localparam int SET_W      = 6;
   localparam int WORD_W     = 3;
   localparam int USE_W      = 8;
   localparam int AGE_W      = 3;
   localparam int TAG_W      = 30;
   localparam int DADDR_W    = SET_W + WAY_W + WORD_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
   localparam logic [USE_W-1:0] USE_MAX = 8'hFF;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;
   localparam logic [1:0] ACT_BAD   = 2'd3;

   localparam logic [2:0] KIND_READ   = 3'd0;
   localparam logic [2:0] KIND_MWRITE = 3'd1;
   localparam logic [2:0] KIND_BREQ   = 3'd2;
   localparam logic [2:0] KIND_ACK    = 3'd3;
   localparam logic [2:0] KIND_ERR    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WPOL  = 3'd4;

   localparam logic [1:0] RP_RANDOM = 2'd0;
   localparam logic [1:0] RP_LFU    = 2'd2;

   typedef enum logic [1:0] {ASEL_ZERO, ASEL_REQ, ASEL_BLOCK, ASEL_STRM} addr_sel_type;
   typedef enum logic [1:0] {MOP_HIT, MOP_FILL, MOP_CLEAN} meta_op_type;
   typedef enum logic [1:0] {DR_HIT, DR_PEND, DR_STRM} dread_type;
   typedef enum logic [1:0] {DW_CPU, DW_FILL, DW_PEND} dwrite_type;

   typedef struct packed {
      logic [MAX_WAYS-1:0][USE_W-1:0] uses;
      logic [MAX_WAYS-1:0][AGE_W-1:0] age;
      logic [MAX_WAYS-1:0]            dirty;
      logic [MAX_WAYS-1:0]            valid;
   } meta_row_type;

   typedef struct packed {
      logic         idle;
      logic         capture;
      logic         emit;
      logic [2:0]   kind;
      logic         last;
      logic         hit;
      addr_sel_type asel;
      logic         dsel_mem;
      logic         dsel_wd;
      logic         meta_we;
      meta_op_type  meta_op;
      logic         dwe;
      dwrite_type   dwop;
      dread_type    drop;
      logic         cap_way;
      logic         lfsr_step;
      logic         mod_start;
      logic         mod_step;
      logic         str_clr;
      logic         str_inc;
      logic         strm_wb;
      logic         pend_set;
      logic         pend_bypass;
      logic         pend_clr;
      logic         fill_inc;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic fill;
      logic p_bypass;
      logic p_write;
      logic fill_done;
      logic bypass;
      logic act_write;
      logic wp;
      logic hit;
      logic hit_held;
      logic need_rand;
      logic vic_dirty;
      logic str_last;
      logic mod_done;
   } status_type;

endpackage

@@ rtl/sacc_datapath.sv @@
// ----------------------------------------------------------------------------
// Cache datapath
// Configuration registers, tag/metadata/data memories, hit and victim logic,
// pending miss record, stream counter, LFSR with serial modulo, result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacc_datapath import sacc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_action,
   input  logic [31:0]           req_address,
   input  logic [31:0]           req_write_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output status_type            st,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [31:0]           rsp_out_address,
   output logic [31:0]           rsp_out_data,
   output logic                  rsp_was_hit,
   output logic                  rsp_last
);

   logic [WCNT_W-1:0] ways_ff;
   logic [1:0]        bwl_ff;
   logic [2:0]        sb_ff;
   logic [1:0]        rp_ff;
   logic              wp_ff;

   logic [1:0]  act_ff;
   logic [31:0] addr_ff;
   logic [31:0] wd_ff;

   logic              pending_ff;
   logic [WORD_W-1:0] fill_cnt_ff;
   logic              p_bypass_ff;
   logic              p_write_ff;
   logic [31:0]       p_data_ff;
   logic [SET_W-1:0]  p_set_ff;
   logic [WAY_W-1:0]  p_way_ff;
   logic [1:0]        p_bl_ff;
   logic [WORD_W-1:0] p_off_ff;
   logic [TAG_W-1:0]  p_tag_ff;
   logic [WCNT_W-1:0] p_ways_ff;

   logic [15:0]       lfsr_ff;
   logic [3:0]        mod_cnt_ff;
   logic [WAY_W-1:0]  rem_ff;
   logic [WAY_W-1:0]  line_way_ff;
   logic              hit_ff;
   logic [WORD_W-1:0] str_cnt_ff;

   logic [MAX_SETS-1:0] rv_ff;
   logic                rv_rd_ff;
   meta_row_type        meta_mem [MAX_SETS];
   meta_row_type        meta_rd_ff;
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_ff;
   logic [31:0]         data_mem [2**DADDR_W];
   logic [31:0]         data_rd_ff;

   logic              rsp_valid_ff;
   logic [2:0]        kind_ff;
   logic [31:0]       oaddr_ff;
   logic [31:0]       odata_ff;
   logic              omem_ff;
   logic              ohit_ff;
   logic              olast_ff;

   logic [WCNT_W-1:0] ways_eff;
   logic [2:0]        sb_eff;
   logic [WORD_W-1:0] cur_wmask;
   logic [WORD_W-1:0] p_wmask;
   logic [SET_W-1:0]  cur_set;
   logic [SET_W-1:0]  req_set;
   logic [SET_W-1:0]  rd_set;
   logic [SET_W-1:0]  meta_wset;
   logic [WORD_W-1:0] cur_off;
   logic [31:0]       tag_shift;
   logic [TAG_W-1:0]  cur_tag;
   logic [31:0]       block_addr;
   logic [31:0]       vaddr;
   logic [31:0]       strm_addr;
   meta_row_type      meta_cur;
   meta_row_type      meta_new;
   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_new;
   logic              hit;
   logic [WAY_W-1:0]  hit_way;
   logic              inv_found;
   logic [WAY_W-1:0]  inv_way;
   logic [WAY_W-1:0]  best;
   logic [WAY_W-1:0]  vic_comb;
   logic [3:0]        mod_t;
   logic [3:0]        rem_new;
   logic [DADDR_W-1:0] dwa;
   logic [DADDR_W-1:0] dra;
   logic [31:0]       dwd;
   logic [31:0]       oaddr_in;

   function automatic logic [SET_W-1:0] f_set(input logic [31:0] a, input logic [1:0] b,
                                              input logic [2:0] s);
      logic [31:0]      sh;
      logic [SET_W-1:0] m;
      sh = a >> (5'd2 + 5'(b));
      m  = SET_W'((7'd1 << s) - 7'd1);
      return sh[SET_W-1:0] & m;
   endfunction

   function automatic meta_row_type f_touch(input meta_row_type r, input logic [WAY_W-1:0] w,
                                            input logic [WCNT_W-1:0] n);
      meta_row_type   o;
      logic [AGE_W-1:0] ref_age;
      o = r;
      ref_age = r.valid[w] ? r.age[w] : AGE_MAX;
      for (int v = 0; v < MAX_WAYS; v++) begin
         if (WCNT_W'(v) < n && WAY_W'(v) != w && r.valid[v] && r.age[v] < ref_age &&
             r.age[v] < AGE_MAX) begin
            o.age[v] = r.age[v] + 3'd1;
         end
      end
      o.age[w] = '0;
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= 4'd1;
         bwl_ff  <= 2'd0;
         sb_ff   <= 3'd0;
         rp_ff   <= 2'd1;
         wp_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WAYS:  ways_ff <= csr_data[WCNT_W-1:0];
            CSR_BLOCK: bwl_ff  <= csr_data[1:0];
            CSR_SETS:  sb_ff   <= csr_data[2:0];
            CSR_REPL:  rp_ff   <= csr_data[1:0];
            CSR_WPOL:  wp_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign ways_eff  = (ways_ff > WCNT_W'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) : ways_ff;
   assign sb_eff    = (sb_ff > 3'(SET_W)) ? 3'(SET_W) : sb_ff;
   assign cur_wmask = WORD_W'((4'd1 << bwl_ff) - 4'd1);
   assign p_wmask   = WORD_W'((4'd1 << p_bl_ff) - 4'd1);
   assign cur_set   = f_set(addr_ff, bwl_ff, sb_eff);
   assign req_set   = f_set(req_address, bwl_ff, sb_eff);
   assign cur_off   = addr_ff[4:2] & cur_wmask;
   assign tag_shift = addr_ff >> (5'd2 + 5'(bwl_ff) + 5'(sb_eff));
   assign cur_tag   = tag_shift[TAG_W-1:0];
   assign block_addr = addr_ff & ~((32'd4 << bwl_ff) - 32'd1);
   assign vaddr     = ({tag_rd_ff[line_way_ff], 2'b00} << (4'(bwl_ff) + 4'(sb_eff))) |
                      (32'(cur_set) << (5'd2 + 5'(bwl_ff)));
   assign strm_addr = (cmd.strm_wb ? vaddr : block_addr) + (32'(str_cnt_ff) << 2);

   always_comb begin
      if (cmd.idle) begin
         rd_set = (req_action == ACT_FILL) ? p_set_ff : req_set;
      end else begin
         rd_set = (act_ff == ACT_FILL) ? p_set_ff : cur_set;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         addr_ff <= req_address & ~32'd3;
         wd_ff   <= req_write_data;
      end
   end

   assign meta_cur = rv_rd_ff ? meta_rd_ff : '0;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      for (int v = MAX_WAYS - 1; v >= 0; v--) begin
         if (WCNT_W'(v) < ways_eff && meta_cur.valid[v] && tag_rd_ff[v] == cur_tag) begin
            hit     = 1'b1;
            hit_way = WAY_W'(v);
         end
         if (WCNT_W'(v) < ways_eff && !meta_cur.valid[v]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(v);
         end
      end
   end

   always_comb begin
      best = '0;
      for (int v = 1; v < MAX_WAYS; v++) begin
         if (WCNT_W'(v) < ways_eff) begin
            if (rp_ff == RP_LFU) begin
               if (meta_cur.uses[v] < meta_cur.uses[best] ||
                   (meta_cur.uses[v] == meta_cur.uses[best] &&
                    meta_cur.age[v] > meta_cur.age[best])) begin
                  best = WAY_W'(v);
               end
            end else if (meta_cur.age[v] > meta_cur.age[best]) begin
               best = WAY_W'(v);
            end
         end
      end
      vic_comb = inv_found ? inv_way : best;
   end

   always_comb begin
      meta_new  = meta_cur;
      meta_wset = cur_set;
      case (cmd.meta_op)
         MOP_HIT: begin
            meta_new = f_touch(meta_cur, hit_way, ways_eff);
            if (meta_cur.uses[hit_way] < USE_MAX) begin
               meta_new.uses[hit_way] = meta_cur.uses[hit_way] + 8'd1;
            end
            if (act_ff == ACT_WRITE) begin
               meta_new.dirty[hit_way] = wp_ff;
            end
         end
         MOP_FILL: begin
            meta_wset = p_set_ff;
            meta_new  = f_touch(meta_cur, p_way_ff, p_ways_ff);
            meta_new.valid[p_way_ff] = 1'b1;
            meta_new.dirty[p_way_ff] = p_write_ff;
            meta_new.uses[p_way_ff]  = 8'd1;
         end
         MOP_CLEAN: meta_new.dirty[line_way_ff] = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      tag_new = tag_rd_ff;
      tag_new[p_way_ff] = p_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
      end else if (cmd.meta_we) begin
         rv_ff[meta_wset] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.meta_we) begin
         meta_mem[meta_wset] <= meta_new;
      end
      if (cmd.meta_we && cmd.meta_op == MOP_FILL) begin
         tag_mem[p_set_ff] <= tag_new;
      end
      rv_rd_ff   <= rv_ff[rd_set];
      meta_rd_ff <= meta_mem[rd_set];
      tag_rd_ff  <= tag_mem[rd_set];
   end

   always_comb begin
      case (cmd.dwop)
         DW_CPU:  begin dwa = {cur_set, hit_way, cur_off};      dwd = wd_ff;     end
         DW_FILL: begin dwa = {p_set_ff, p_way_ff, fill_cnt_ff}; dwd = wd_ff;     end
         default: begin dwa = {p_set_ff, p_way_ff, p_off_ff};   dwd = p_data_ff; end
      endcase
      case (cmd.drop)
         DR_HIT:  dra = {cur_set, hit_way, cur_off};
         DR_PEND: dra = {p_set_ff, p_way_ff, p_off_ff};
         default: dra = {cur_set, line_way_ff, str_cnt_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.dwe) begin
         data_mem[dwa] <= dwd;
      end
      data_rd_ff <= data_mem[dra];
   end

   assign mod_t   = {rem_ff, lfsr_ff[4'd15 - mod_cnt_ff]};
   assign rem_new = (mod_t >= ways_eff) ? mod_t - ways_eff : mod_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= 16'hACE1;
      end else if (cmd.lfsr_step) begin
         lfsr_ff <= {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? 16'hB400 : 16'h0000);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         mod_cnt_ff <= '0;
         rem_ff     <= '0;
      end else if (cmd.mod_step) begin
         mod_cnt_ff <= mod_cnt_ff + 4'd1;
         rem_ff     <= rem_new[WAY_W-1:0];
      end
      if (cmd.cap_way) begin
         line_way_ff <= hit ? hit_way : vic_comb;
         hit_ff      <= hit;
      end else if (cmd.mod_step && st.mod_done) begin
         line_way_ff <= rem_new[WAY_W-1:0];
      end
      if (cmd.str_clr) begin
         str_cnt_ff <= '0;
      end else if (cmd.str_inc) begin
         str_cnt_ff <= str_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         fill_cnt_ff <= '0;
      end else if (cmd.pend_set) begin
         pending_ff  <= 1'b1;
         fill_cnt_ff <= '0;
      end else if (cmd.pend_clr) begin
         pending_ff  <= 1'b0;
         fill_cnt_ff <= '0;
      end else if (cmd.fill_inc) begin
         fill_cnt_ff <= fill_cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_set) begin
         p_bypass_ff <= cmd.pend_bypass;
         p_write_ff  <= (act_ff == ACT_WRITE);
         p_data_ff   <= wd_ff;
         p_set_ff    <= cur_set;
         p_way_ff    <= line_way_ff;
         p_bl_ff     <= bwl_ff;
         p_off_ff    <= cur_off;
         p_tag_ff    <= cur_tag;
         p_ways_ff   <= ways_eff;
      end
   end

   always_comb begin
      case (cmd.asel)
         ASEL_REQ:   oaddr_in = addr_ff;
         ASEL_BLOCK: oaddr_in = block_addr;
         ASEL_STRM:  oaddr_in = strm_addr;
         default:    oaddr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         kind_ff  <= cmd.kind;
         oaddr_ff <= oaddr_in;
         odata_ff <= cmd.dsel_wd ? wd_ff : 32'd0;
         omem_ff  <= cmd.dsel_mem;
         ohit_ff  <= cmd.hit;
         olast_ff <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_address = oaddr_ff;
   assign rsp_out_data    = omem_ff ? data_rd_ff : odata_ff;
   assign rsp_was_hit     = ohit_ff;
   assign rsp_last        = olast_ff;

   always_comb begin
      st.err       = (act_ff == ACT_BAD) || ((act_ff == ACT_FILL) != pending_ff);
      st.fill      = (act_ff == ACT_FILL);
      st.p_bypass  = p_bypass_ff;
      st.p_write   = p_write_ff;
      st.fill_done = (fill_cnt_ff == p_wmask);
      st.bypass    = (ways_eff == '0);
      st.act_write = (act_ff == ACT_WRITE);
      st.wp        = wp_ff;
      st.hit       = hit;
      st.hit_held  = hit_ff;
      st.need_rand = !inv_found && (rp_ff == RP_RANDOM);
      st.vic_dirty = meta_cur.valid[line_way_ff] && meta_cur.dirty[line_way_ff];
      st.str_last  = (str_cnt_ff == cur_wmask);
      st.mod_done  = (mod_cnt_ff == 4'd15);
   end

endmodule

@@ rtl/sacc_controller.sv @@
// ----------------------------------------------------------------------------
// Cache controller sequencer
// Steps each accepted item through lookup, victim choice, write-back,
// write-through streaming and fill completion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "set_assoc_cache_controller_top_assert.svh"

module sacc_controller import sacc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type st,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [3:0] {
      S_IDLE, S_EVAL, S_FIN, S_MOD, S_VIC, S_WB, S_REQ, S_WT, S_ACK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cmd.idle = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (st.err) begin
               cmd.emit = 1'b1; cmd.kind = KIND_ERR; cmd.last = 1'b1;
               state_in = S_IDLE;
            end else if (st.fill) begin
               if (st.p_bypass) begin
                  cmd.emit = 1'b1; cmd.kind = KIND_READ; cmd.last = 1'b1;
                  cmd.dsel_wd  = 1'b1;
                  cmd.pend_clr = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.dwe = 1'b1; cmd.dwop = DW_FILL;
                  cmd.fill_inc = 1'b1;
                  if (st.fill_done) begin
                     cmd.meta_we = 1'b1; cmd.meta_op = MOP_FILL;
                     cmd.pend_clr = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end else if (st.bypass) begin
               cmd.cap_way = 1'b1;
               if (st.act_write) begin
                  cmd.emit = 1'b1; cmd.kind = KIND_MWRITE;
                  cmd.asel = ASEL_REQ; cmd.dsel_wd = 1'b1;
                  state_in = S_ACK;
               end else begin
                  cmd.pend_set = 1'b1; cmd.pend_bypass = 1'b1;
                  cmd.emit = 1'b1; cmd.kind = KIND_BREQ; cmd.asel = ASEL_REQ;
                  cmd.last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.cap_way = 1'b1;
               if (st.hit) begin
                  cmd.meta_we = 1'b1; cmd.meta_op = MOP_HIT;
                  if (st.act_write) begin
                     cmd.dwe = 1'b1; cmd.dwop = DW_CPU;
                     if (st.wp) begin
                        cmd.emit = 1'b1; cmd.kind = KIND_ACK; cmd.hit = 1'b1;
                        cmd.last = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        cmd.str_clr = 1'b1;
                        state_in = S_WT;
                     end
                  end else begin
                     cmd.drop = DR_HIT;
                     cmd.emit = 1'b1; cmd.kind = KIND_READ; cmd.dsel_mem = 1'b1;
                     cmd.hit = 1'b1; cmd.last = 1'b1;
                     state_in = S_IDLE;
                  end
               end else if (st.act_write && !st.wp) begin
                  cmd.emit = 1'b1; cmd.kind = KIND_MWRITE;
                  cmd.asel = ASEL_REQ; cmd.dsel_wd = 1'b1;
                  state_in = S_ACK;
               end else if (st.need_rand) begin
                  cmd.lfsr_step = 1'b1;
                  cmd.mod_start = 1'b1;
                  state_in = S_MOD;
               end else begin
                  state_in = S_VIC;
               end
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (st.mod_done) begin
               state_in = S_VIC;
            end
         end
         S_VIC: begin
            if (st.vic_dirty) begin
               cmd.meta_we = 1'b1; cmd.meta_op = MOP_CLEAN;
               cmd.str_clr = 1'b1;
               state_in = S_WB;
            end else begin
               cmd.pend_set = 1'b1;
               cmd.emit = 1'b1; cmd.kind = KIND_BREQ; cmd.asel = ASEL_BLOCK;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WB: begin
            cmd.drop = DR_STRM; cmd.strm_wb = 1'b1;
            cmd.emit = 1'b1; cmd.kind = KIND_MWRITE;
            cmd.asel = ASEL_STRM; cmd.dsel_mem = 1'b1;
            if (st.str_last) begin
               state_in = S_REQ;
            end else begin
               cmd.str_inc = 1'b1;
            end
         end
         S_REQ: begin
            cmd.pend_set = 1'b1;
            cmd.emit = 1'b1; cmd.kind = KIND_BREQ; cmd.asel = ASEL_BLOCK;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         S_WT: begin
            cmd.drop = DR_STRM;
            cmd.emit = 1'b1; cmd.kind = KIND_MWRITE;
            cmd.asel = ASEL_STRM; cmd.dsel_mem = 1'b1;
            if (st.str_last) begin
               state_in = S_ACK;
            end else begin
               cmd.str_inc = 1'b1;
            end
         end
         S_ACK: begin
            cmd.emit = 1'b1; cmd.kind = KIND_ACK; cmd.hit = st.hit_held;
            cmd.last = 1'b1;
            state_in = S_IDLE;
         end
         S_FIN: begin
            cmd.emit = 1'b1; cmd.last = 1'b1;
            if (st.p_write) begin
               cmd.dwe = 1'b1; cmd.dwop = DW_PEND;
               cmd.kind = KIND_ACK;
            end else begin
               cmd.drop = DR_PEND;
               cmd.kind = KIND_READ; cmd.dsel_mem = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `SACC_ASSERT_NEXT(a_accept_eval, state_ff == S_IDLE && start, state_ff == S_EVAL, "accepted beat did not reach evaluation")
   `SACC_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, state_ff == S_IDLE, "final beat did not release the block")
   `SACC_ASSERT_NEXT(a_wb_req, state_ff == S_WB && st.str_last, state_ff == S_REQ, "write-back did not end in a block request")

endmodule

@@ rtl/set_assoc_cache_controller_top.sv @@
// ----------------------------------------------------------------------------
// Set-associative cache controller
// Lookup, replacement and write policy control over on-chip tag, state and
// data memories, with write-back and fill traffic as result beats.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: an item is taken on a rising edge with start high and
//    busy low (req_action, req_address, req_write_data).
//  - Result channel: each beat is on rsp_* for one cycle under rsp_valid;
//    rsp_last marks the final beat of an item. The receiver cannot stall.
//  - Register channel: csr_valid/csr_ready with csr_index and csr_data;
//    csr_ready is always high. Write only while the block is idle.
//  - Read hit, errors, bypass read, write-back write hit: result from
//    evaluation, next item accepted in the result cycle. Partial fills emit none.
//  - Write-through hit: block words streamed, then an acknowledge. Final
//    fill: a finish state. Bypass write, write-through write miss: an
//    acknowledge. Clean miss: victim choice, dirty victim adds write-back and
//    block request. Random choice with all ways valid adds serial LFSR modulo.
//  - 1R1W data memory; write-back and write-through stream one word/cycle.
//  - Reset: synchronous; all lines invalid, no miss pending, default
//    geometry of one way, one word per block, one set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_controller_top import sacc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_action,
   input  logic [31:0]           req_address,
   input  logic [31:0]           req_write_data,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_kind,
   output logic [31:0]           rsp_out_address,
   output logic [31:0]           rsp_out_data,
   output logic                  rsp_was_hit,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   sacc_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   sacc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .st              (st),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_out_address (rsp_out_address),
      .rsp_out_data    (rsp_out_data),
      .rsp_was_hit     (rsp_was_hit),
      .rsp_last        (rsp_last)
   );

endmodule
